/* rtl/core/imu_ocs_pkg.sv */
package imu_ocs_pkg;

    localparam int RAW_W           = 16;
    localparam int NUM_AXES        = 6;
    localparam int OFF_W           = 17;
    localparam int DIFF_W          = 18;
    localparam int ACC_W           = 17;
    localparam int ACCZ_W          = 18;
    localparam int TEMP_W          = 17;
    localparam int GYRO_W          = 17;
    localparam int S_TDATA_W       = 112;
    localparam int M_TDATA_W       = 120;
    localparam int TEMP_SLOT       = 3;

    localparam int CAL_SAMPLES_DEF = 200;
    localparam int ACCEL_ONE_G     = 16384;

    // gyro: round(d * 128 / 131) by reciprocal multiply on the magnitude
    localparam int GYRO_DIV        = 131;
    localparam int GYRO_SHIFT      = 7;
    localparam int GYRO_HALF       = GYRO_DIV / 2;
    localparam int GYRO_IN_W       = 24;
    localparam int GYRO_K          = GYRO_IN_W + $clog2(GYRO_DIV);
    localparam int GYRO_P_W        = 2 * GYRO_IN_W + 1;
    localparam longint unsigned GYRO_M_L =
        ((64'd1 << GYRO_K) + 64'(GYRO_DIV) - 64'd1) / 64'(GYRO_DIV);
    localparam logic [GYRO_IN_W:0] GYRO_M = GYRO_M_L[GYRO_IN_W:0];

    // temperature: round((320 * t + 3974464) / 425)
    localparam int TEMP_SCALE      = 320;
    localparam int TEMP_BIAS       = 3974464;
    localparam int TEMP_DIV        = 425;
    localparam int TEMP_HALF       = TEMP_DIV / 2;
    localparam int TEMP_N_W        = 25;
    localparam int TEMP_IN_W       = 24;
    localparam int TEMP_K          = TEMP_IN_W + $clog2(TEMP_DIV);
    localparam int TEMP_P_W        = 2 * TEMP_IN_W + 1;
    localparam int TEMP_Q_W        = TEMP_P_W - TEMP_K;
    localparam longint unsigned TEMP_M_L =
        ((64'd1 << TEMP_K) + 64'(TEMP_DIV) - 64'd1) / 64'(TEMP_DIV);
    localparam logic [TEMP_IN_W:0] TEMP_M = TEMP_M_L[TEMP_IN_W:0];

    typedef enum logic [1:0] {
        ST_MEAS   = 2'd0,
        ST_SAMPLE = 2'd1,
        ST_DONE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LK_ACCEL   = 2'd0,
        LK_ACCEL_Z = 2'd1,
        LK_GYRO    = 2'd2
    } lane_kind_t;

    typedef struct packed {
        logic en;
        logic take;
        logic keep;
        logic upd;
    } lane_ctl_t;

    typedef struct packed {
        status_t                   status;
        logic signed [ACC_W-1:0]   accel_x;
        logic signed [ACC_W-1:0]   accel_y;
        logic signed [ACCZ_W-1:0]  accel_z;
        logic signed [TEMP_W-1:0]  temperature;
        logic signed [GYRO_W-1:0]  gyro_x;
        logic signed [GYRO_W-1:0]  gyro_y;
        logic signed [GYRO_W-1:0]  gyro_z;
    } result_t;

endpackage

/* rtl/core/imu_ocs_lane.sv */
module imu_ocs_lane
    import imu_ocs_pkg::*;
#(
    parameter int         CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter lane_kind_t KIND        = LK_ACCEL
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctl_t                ctl,
    input  logic signed [RAW_W-1:0]  raw,
    output logic signed [DIFF_W-1:0] res
);

    localparam int CAL_L   = $clog2(CAL_SAMPLES);
    localparam int SUM_W   = RAW_W + CAL_L;
    localparam int CAL_K   = SUM_W + CAL_L;
    localparam int CAL_P_W = 2 * SUM_W + 1;
    localparam longint unsigned CAL_M_L =
        ((64'd1 << CAL_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [SUM_W:0]     CAL_M = CAL_M_L[SUM_W:0];
    localparam logic [OFF_W-1:0]   ONE_G =
        (KIND == LK_ACCEL_Z) ? OFF_W'(ACCEL_ONE_G) : '0;

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_add;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic signed [RAW_W-1:0]  s1_raw_reg;
    logic signed [RAW_W-1:0]  s2_raw_reg;
    logic [SUM_W-1:0]         cal_mag;
    logic [CAL_P_W-1:0]       s2_prod_reg;
    logic                     s2_neg_reg;
    logic [OFF_W-1:0]         cal_quot;
    logic [OFF_W-1:0]         off_next;
    logic signed [OFF_W-1:0]  off_reg;
    logic signed [DIFF_W-1:0] s3_diff_reg;
    logic signed [DIFF_W-1:0] res_reg;

    assign sum_add  = sum_reg + SUM_W'(raw);
    assign cal_mag  = s1_sum_reg[SUM_W-1] ? $unsigned(-s1_sum_reg) : $unsigned(s1_sum_reg);
    assign cal_quot = s2_prod_reg[CAL_P_W-1:CAL_K];
    assign off_next = (s2_neg_reg ? (~cal_quot + 1'b1) : cal_quot) - ONE_G;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            off_reg <= '0;
        end else begin
            if (ctl.take) begin
                sum_reg <= ctl.keep ? sum_add : '0;
            end
            if (ctl.upd) begin
                off_reg <= $signed(off_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            s1_sum_reg  <= sum_add;
            s1_raw_reg  <= raw;
            s2_prod_reg <= CAL_P_W'(cal_mag) * CAL_P_W'(CAL_M);
            s2_neg_reg  <= s1_sum_reg[SUM_W-1];
            s2_raw_reg  <= s1_raw_reg;
            s3_diff_reg <= DIFF_W'(s2_raw_reg) - DIFF_W'(off_reg);
        end
    end

    generate
        if (KIND == LK_GYRO) begin : g_gyro
            logic [GYRO_W-1:0]    d_mag;
            logic [GYRO_IN_W-1:0] g_num;
            logic [GYRO_P_W-1:0]  s4_prod_reg;
            logic                 s4_neg_reg;
            logic [GYRO_W-1:0]    g_quot;

            assign d_mag  = s3_diff_reg[DIFF_W-1] ? GYRO_W'($unsigned(-s3_diff_reg))
                                                  : GYRO_W'($unsigned(s3_diff_reg));
            assign g_num  = (GYRO_IN_W'(d_mag) << GYRO_SHIFT) + GYRO_IN_W'(GYRO_HALF);
            assign g_quot = s4_prod_reg[GYRO_P_W-1:GYRO_K];

            always_ff @(posedge aclk) begin
                if (ctl.en) begin
                    s4_prod_reg <= GYRO_P_W'(g_num) * GYRO_P_W'(GYRO_M);
                    s4_neg_reg  <= s3_diff_reg[DIFF_W-1];
                    res_reg     <= s4_neg_reg ? $signed(~DIFF_W'(g_quot) + 1'b1)
                                              : $signed(DIFF_W'(g_quot));
                end
            end
        end else begin : g_accel
            logic signed [DIFF_W-1:0] s4_diff_reg;

            always_ff @(posedge aclk) begin
                if (ctl.en) begin
                    s4_diff_reg <= s3_diff_reg;
                    res_reg     <= s4_diff_reg;
                end
            end
        end
    endgenerate

    assign res = res_reg;

endmodule

/* rtl/core/imu_ocs_temp.sv */
module imu_ocs_temp
    import imu_ocs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [RAW_W-1:0]  raw,
    output logic signed [TEMP_W-1:0] res
);

    logic signed [RAW_W-1:0]    t1_raw_reg;
    logic signed [TEMP_N_W-1:0] t2_num_reg;
    logic [TEMP_IN_W-1:0]       n_mag;
    logic [TEMP_IN_W-1:0]       t3_mag_reg;
    logic                       t3_neg_reg;
    logic [TEMP_P_W-1:0]        t4_prod_reg;
    logic                       t4_neg_reg;
    logic [TEMP_Q_W-1:0]        t_quot;
    logic signed [TEMP_W-1:0]   res_reg;

    assign n_mag  = t2_num_reg[TEMP_N_W-1] ? TEMP_IN_W'($unsigned(-t2_num_reg))
                                           : TEMP_IN_W'($unsigned(t2_num_reg));
    assign t_quot = t4_prod_reg[TEMP_P_W-1:TEMP_K];

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_raw_reg  <= raw;
            t2_num_reg  <= TEMP_N_W'(t1_raw_reg) * TEMP_N_W'(TEMP_SCALE)
                           + TEMP_N_W'(TEMP_BIAS);
            t3_mag_reg  <= n_mag + TEMP_IN_W'(TEMP_HALF);
            t3_neg_reg  <= t2_num_reg[TEMP_N_W-1];
            t4_prod_reg <= TEMP_P_W'(t3_mag_reg) * TEMP_P_W'(TEMP_M);
            t4_neg_reg  <= t3_neg_reg;
            res_reg     <= t4_neg_reg ? $signed(~TEMP_W'(t_quot) + 1'b1)
                                      : $signed(TEMP_W'(t_quot));
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/imu_ocs_merge.sv */
module imu_ocs_merge
    import imu_ocs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  result_t              in_res,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    logic [M_TDATA_W-1:0] in_data;
    logic                 load;
    logic                 out_v_reg;
    logic                 skid_v_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;
    status_t              out_status_reg;
    status_t              skid_status_reg;

    // zero every value field unless this is a measurement result
    assign in_data  = (in_res.status == ST_MEAS) ?
                      {in_res.gyro_z, in_res.gyro_y, in_res.gyro_x, in_res.temperature,
                       in_res.accel_z, in_res.accel_y, in_res.accel_x} : '0;
    assign in_ready = !skid_v_reg;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (!out_v_reg || m_tready) begin
                if (skid_v_reg) begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= 1'b0;
                end else begin
                    out_v_reg <= load;
                end
            end else if (load) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            if (skid_v_reg) begin
                out_data_reg   <= skid_data_reg;
                out_status_reg <= skid_status_reg;
            end else if (load) begin
                out_data_reg   <= in_data;
                out_status_reg <= in_res.status;
            end
        end else if (load) begin
            skid_data_reg   <= in_data;
            skid_status_reg <= in_res.status;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

/* rtl/core/imu_offset_calibrate_and_scale_unit.sv */
// Six-axis IMU offset calibration and scaling.
// Input stream: one sensor frame per transaction. s_tdata carries the raw
// accelerometer, temperature and gyro words; s_tuser selects a measurement
// frame (0) or a calibration sample frame (1).
// Output stream: one result transaction per input transaction, in order.
// m_tuser gives the status: measurement, sample taken, or calibration done.
// After CAL_SAMPLES consecutive calibration frames the offsets are updated;
// a measurement frame in the middle of a run drops the partial sums.
// Throughput: one frame per cycle while the output skid is not full. Between
// acceptance and m_tvalid a frame passes the per-axis lane pipeline (sum,
// reciprocal multiply for the average, offset subtract, reciprocal multiply
// for the gyro scale, sign restore) that the temperature path matches stage for stage.
// Reset clears sums, sample count and offsets; outputs start uncalibrated.
// When the receiver stalls, a two-entry output skid absorbs results and
// s_tready drops only once both entries are full.
module imu_offset_calibrate_and_scale_unit
    import imu_ocs_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [1:0]           m_tuser
);

    localparam int CNT_W      = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int PIPE_DEPTH = 5;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
    localparam int AXIS_SLOT [NUM_AXES] = '{0, 1, 2, 4, 5, 6};
    localparam lane_kind_t AXIS_KIND [NUM_AXES] =
        '{LK_ACCEL, LK_ACCEL, LK_ACCEL_Z, LK_GYRO, LK_GYRO, LK_GYRO};

    typedef struct packed {
        logic    valid;
        status_t status;
    } stage_t;

    logic                     en;
    logic                     take;
    logic                     fin;
    status_t                  status_in;
    logic [CNT_W-1:0]         cnt_reg;
    lane_ctl_t                lane_ctl;
    stage_t                   stg_reg [PIPE_DEPTH];
    logic signed [DIFF_W-1:0] lane_res [NUM_AXES];
    logic signed [TEMP_W-1:0] temp_res;
    result_t                  res;

    assign take      = s_tvalid && en;
    assign fin       = s_tuser && (cnt_reg == CNT_LAST);
    assign status_in = !s_tuser ? ST_MEAS : (fin ? ST_DONE : ST_SAMPLE);
    assign s_tready  = en;

    assign lane_ctl.en   = en;
    assign lane_ctl.take = take;
    assign lane_ctl.keep = s_tuser && !fin;
    assign lane_ctl.upd  = en && stg_reg[1].valid && (stg_reg[1].status == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                stg_reg[i] <= '0;
            end
        end else begin
            if (take) begin
                cnt_reg <= lane_ctl.keep ? cnt_reg + 1'b1 : '0;
            end
            if (en) begin
                stg_reg[0].valid  <= take;
                stg_reg[0].status <= status_in;
                for (int i = 1; i < PIPE_DEPTH; i++) begin
                    stg_reg[i] <= stg_reg[i-1];
                end
            end
        end
    end

    generate
        for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
            imu_ocs_lane #(
                .CAL_SAMPLES (CAL_SAMPLES),
                .KIND        (AXIS_KIND[i])
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl),
                .raw     (s_tdata[AXIS_SLOT[i]*RAW_W +: RAW_W]),
                .res     (lane_res[i])
            );
        end
    endgenerate

    imu_ocs_temp u_temp (
        .aclk (aclk),
        .en   (en),
        .raw  (s_tdata[TEMP_SLOT*RAW_W +: RAW_W]),
        .res  (temp_res)
    );

    assign res.status      = stg_reg[PIPE_DEPTH-1].status;
    assign res.accel_x     = lane_res[0][ACC_W-1:0];
    assign res.accel_y     = lane_res[1][ACC_W-1:0];
    assign res.accel_z     = lane_res[2][ACCZ_W-1:0];
    assign res.temperature = temp_res;
    assign res.gyro_x      = lane_res[3][GYRO_W-1:0];
    assign res.gyro_y      = lane_res[4][GYRO_W-1:0];
    assign res.gyro_z      = lane_res[5][GYRO_W-1:0];

    imu_ocs_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_reg[PIPE_DEPTH-1].valid),
        .in_ready (en),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LAST)
        else $error("sample count past end of run");

    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !lane_ctl.keep |=> cnt_reg == '0)
        else $error("run not restarted after finish or measurement");

    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");
`endif

endmodule

/* sim/imu_offset_calibrate_and_scale_unit_tb.sv */
module imu_offset_calibrate_and_scale_unit_tb;
    import imu_ocs_pkg::*;

    localparam int    TEMP_GAIN    = 320;
    localparam int    TEMP_OFFSET  = 3974464;
    localparam int    TEMP_DIVISOR = 425;
    localparam int    GYRO_GAIN    = 128;
    localparam int    GYRO_DIVISOR = 131;
    localparam int    HOLD_CYCLES  = 500;
    localparam int    PHASE_ITEMS  = 300;
    localparam int    TAIL_CYCLES  = 20;
    localparam logic [RAW_W-1:0] WORD_MAX = 16'sh7fff;
    localparam logic [RAW_W-1:0] WORD_MIN = 16'sh8000;

    typedef struct {
        logic                    cal;
        logic signed [RAW_W-1:0] ax;
        logic signed [RAW_W-1:0] ay;
        logic signed [RAW_W-1:0] az;
        logic signed [RAW_W-1:0] temp;
        logic signed [RAW_W-1:0] gx;
        logic signed [RAW_W-1:0] gy;
        logic signed [RAW_W-1:0] gz;
    } frame_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // action
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z
    logic [M_TDATA_W-1:0] m_tdata;
    // status
    logic [1:0]           m_tuser;

    frame_t  pending_frames[$];
    result_t expected_results[$];

    int axis_sum[NUM_AXES];
    int axis_off[NUM_AXES];
    int sample_cnt     = 0;
    int queued_cnt     = 0;
    int fail_cnt       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_tag       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    bit send_hold      = 1'b0;

    imu_offset_calibrate_and_scale_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic longint round_nearest(longint num, longint den);
        if (num >= 0) begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    function automatic void clear_run();
        foreach (axis_sum[i]) begin
            axis_sum[i] = 0;
        end
        sample_cnt = 0;
    endfunction

    function automatic result_t calibrate_and_scale(frame_t f);
        result_t r;
        int      ax[NUM_AXES];
        ax = '{f.ax, f.ay, f.az, f.gx, f.gy, f.gz};
        r  = '0;
        if (f.cal) begin
            foreach (ax[i]) begin
                axis_sum[i] += ax[i];
            end
            sample_cnt++;
            if (sample_cnt >= CAL_SAMPLES_DEF) begin
                foreach (ax[i]) begin
                    axis_off[i] = axis_sum[i] / CAL_SAMPLES_DEF;
                end
                axis_off[2] -= ACCEL_ONE_G;
                clear_run();
                r.status = ST_DONE;
            end else begin
                r.status = ST_SAMPLE;
            end
        end else begin
            clear_run();
            r.status      = ST_MEAS;
            r.accel_x     = ACC_W'(ax[0] - axis_off[0]);
            r.accel_y     = ACC_W'(ax[1] - axis_off[1]);
            r.accel_z     = ACCZ_W'(ax[2] - axis_off[2]);
            r.temperature = TEMP_W'(round_nearest(longint'(f.temp) * TEMP_GAIN + TEMP_OFFSET,
                                                  TEMP_DIVISOR));
            r.gyro_x      = GYRO_W'(round_nearest(longint'(ax[3] - axis_off[3]) * GYRO_GAIN,
                                                  GYRO_DIVISOR));
            r.gyro_y      = GYRO_W'(round_nearest(longint'(ax[4] - axis_off[4]) * GYRO_GAIN,
                                                  GYRO_DIVISOR));
            r.gyro_z      = GYRO_W'(round_nearest(longint'(ax[5] - axis_off[5]) * GYRO_GAIN,
                                                  GYRO_DIVISOR));
        end
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic frame_t random_frame(logic cal);
        frame_t f;
        f = '{cal, rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word()};
        return f;
    endfunction

    task automatic push_frame(frame_t f);
        pending_frames.push_back(f);
        queued_cnt++;
    endtask

    task automatic push_same(logic cal, logic [RAW_W-1:0] w);
        frame_t f;
        f = '{cal, w, w, w, w, w, w, w};
        push_frame(f);
    endtask

    task automatic push_noisy(logic cal, logic [RAW_W-1:0] base[7]);
        frame_t f;
        logic [RAW_W-1:0] w[7];
        foreach (w[i]) begin
            w[i] = RAW_W'(int'(base[i]) + int'($urandom_range(64)) - 32);
        end
        f = '{cal, w[0], w[1], w[2], w[3], w[4], w[5], w[6]};
        push_frame(f);
    endtask

    task automatic gen_segment();
        logic [RAW_W-1:0] base[7];
        int               kind;
        int               mode;
        int               n;
        kind = $urandom_range(9);
        if (kind < 4) begin
            mode = $urandom_range(3);
            foreach (base[i]) begin
                base[i] = rand_word();
            end
            for (int i = 0; i < CAL_SAMPLES_DEF; i++) begin
                if (mode == 0) begin
                    push_same(1'b1, WORD_MAX);
                end else if (mode == 1) begin
                    push_same(1'b1, WORD_MIN);
                end else begin
                    push_noisy(1'b1, base);
                end
            end
            if (mode == 0) begin
                push_same(1'b0, WORD_MIN);
            end else if (mode == 1) begin
                push_same(1'b0, WORD_MAX);
            end
            n = $urandom_range(25, 3);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1)) begin
                    push_noisy(1'b0, base);
                end else begin
                    push_frame(random_frame(1'b0));
                end
            end
        end else if (kind < 6) begin
            n = $urandom_range(CAL_SAMPLES_DEF - 1, 1);
            for (int i = 0; i < n; i++) begin
                push_frame(random_frame(1'b1));
            end
            push_frame(random_frame(1'b0));
        end else begin
            n = $urandom_range(20, 1);
            for (int i = 0; i < n; i++) begin
                push_frame(random_frame($urandom_range(3) == 0));
            end
        end
    endtask

    task automatic gen_phase(int phase_end);
        while (queued_cnt < phase_end) begin
            gen_segment();
        end
    endtask

    task automatic drain_queue();
        while (pending_frames.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        frame_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_frames.size() != 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt      = pending_frames.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cal;
                s_tdata  <= {nxt.gz, nxt.gy, nxt.gx, nxt.temp, nxt.az, nxt.ay, nxt.ax};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        frame_t  cur;
        result_t want;
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cur.cal = s_tuser;
                {cur.gz, cur.gy, cur.gx, cur.temp, cur.az, cur.ay, cur.ax} = s_tdata;
                expected_results.push_back(calibrate_and_scale(cur));
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                {got.gyro_z, got.gyro_y, got.gyro_x, got.temperature,
                 got.accel_z, got.accel_y, got.accel_x} = m_tdata;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no frame outstanding");
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status",          want.status,      got.status);
                    compare_field("accel_x_out",     want.accel_x,     got.accel_x);
                    compare_field("accel_y_out",     want.accel_y,     got.accel_y);
                    compare_field("accel_z_out",     want.accel_z,     got.accel_z);
                    compare_field("temperature_out", want.temperature, got.temperature);
                    compare_field("gyro_x_out",      want.gyro_x,      got.gyro_x);
                    compare_field("gyro_y_out",      want.gyro_y,      got.gyro_y);
                    compare_field("gyro_z_out",      want.gyro_z,      got.gyro_z);
                end
            end
        end
    end

    initial begin
        frame_t f;
        int     phase_end;
        foreach (axis_sum[i]) begin
            axis_sum[i] = 0;
            axis_off[i] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // uncalibrated extremes and bit patterns
        push_same(1'b0, '0);
        push_same(1'b0, WORD_MAX);
        push_same(1'b0, WORD_MIN);
        push_same(1'b0, 16'h5555);
        push_same(1'b0, 16'haaaa);
        push_same(1'b0, '1);
        f      = random_frame(1'b0);
        f.temp = 16'sd1;
        push_frame(f);
        f      = random_frame(1'b0);
        f.temp = -16'sd1;
        push_frame(f);
        // partial runs dropped by a measurement
        push_same(1'b1, WORD_MAX);
        push_same(1'b1, WORD_MIN);
        push_frame(random_frame(1'b1));
        push_same(1'b0, WORD_MAX);
        push_same(1'b0, WORD_MIN);
        push_frame(random_frame(1'b1));
        push_frame(random_frame(1'b0));

        // back-to-back, then a long receiver hold-off while the sender keeps offering
        phase_end = queued_cnt + PHASE_ITEMS;
        gen_phase(phase_end);
        hold_tag++;
        drain_queue();

        @(negedge aclk);
        send_idle_pct = 55;
        phase_end += PHASE_ITEMS;
        gen_phase(phase_end);
        drain_queue();

        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        phase_end += PHASE_ITEMS;
        gen_phase(phase_end);
        while (pending_frames.size() > PHASE_ITEMS / 2) begin
            @(negedge aclk);
        end
        // hold the sender until every outstanding result has come back
        send_hold = 1'b1;
        while (expected_results.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        send_hold = 1'b0;
        drain_queue();

        @(negedge aclk);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        phase_end += PHASE_ITEMS;
        gen_phase(phase_end);
        drain_queue();

        while (s_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
